### sv/wslsc_pkg.sv
`timescale 1ns / 1ps
// Shared widths for the window-sum limited run counter.
// No dependencies; every other file except wslsc_ram refers to it by scoped names.
package wslsc_pkg;

   localparam int ELEM_W  = 32;   // element width
   localparam int LIMIT_W = 48;   // sum limit and run count width
   localparam int TOTAL_W = 49;   // window sum, one bit above the limit
   localparam int LEN_W   = 11;   // reported window length

endpackage

### sv/wslsc_req_if.sv
`timescale 1ns / 1ps
// Input channel of the run counter: one element word per handshake.
// Depends on wslsc_pkg for the field widths.
interface wslsc_req_if;
   logic                         valid;
   logic                         ready;
   logic [wslsc_pkg::ELEM_W-1:0] element;
   logic                         first;

   modport source (output valid, element, first, input ready);
   modport sink   (input valid, element, first, output ready);
endinterface

### sv/wslsc_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the run counter: one result word per handshake.
// Depends on wslsc_pkg for the field widths.
interface wslsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wslsc_pkg::LIMIT_W-1:0] run_count;
   logic [wslsc_pkg::LEN_W-1:0]   window_length;
   logic                          overflow;

   modport source (output valid, run_count, window_length, overflow, input ready);
   modport sink   (input valid, run_count, window_length, overflow, output ready);
endinterface

### sv/wslsc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module wslsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/wslsc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer and datapath of the run counter: ring pointers, window sum,
// run count and the result register. Depends on wslsc_pkg, the two channel
// interfaces and wslsc_ram.
module wslsc_ctrl #(
   parameter int WINDOW_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [wslsc_pkg::LIMIT_W-1:0] sum_limit,
   wslsc_req_if.sink                     req_ch,
   wslsc_rsp_if.source                   rsp_ch
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int FW = $clog2(WINDOW_DEPTH + 1);
   localparam int EW = wslsc_pkg::ELEM_W;
   localparam int LW = wslsc_pkg::LIMIT_W;
   localparam int TW = wslsc_pkg::TOTAL_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_FULL,
      S_TRIM,
      S_DROP
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     oldest_ff;
   logic [AW-1:0]     tail_ff;
   logic [FW-1:0]     fill_ff;
   logic [TW-1:0]     total_ff;
   logic [LW-1:0]     count_ff;
   logic [EW-1:0]     elem_ff;
   logic              ovf_ff;

   logic              rsp_valid_ff;
   logic [LW-1:0]     out_count_ff;
   logic [wslsc_pkg::LEN_W-1:0] out_len_ff;
   logic              out_ovf_ff;

   // values seen at acceptance, after a start-of-sequence clear
   logic [AW-1:0]     acc_oldest;
   logic [AW-1:0]     acc_tail;
   logic [FW-1:0]     acc_fill;
   logic [TW-1:0]     acc_total;
   logic [LW-1:0]     acc_count;
   logic              acc_full;
   logic              accept;
   logic              need_drop;
   logic              out_free;
   logic              out_load;
   logic [LW:0]       count_sum;
   logic [LW-1:0]     count_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [EW-1:0]     wr_data;
   logic              rd_en;
   logic [EW-1:0]     rd_data;

   logic [FW:0]       ring_sum;
   logic [FW:0]       ring_end;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      ptr_next = (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign accept     = req_ch.valid && (state_ff == S_IDLE);
   assign acc_oldest = req_ch.first ? '0 : oldest_ff;
   assign acc_tail   = req_ch.first ? '0 : tail_ff;
   assign acc_fill   = req_ch.first ? '0 : fill_ff;
   assign acc_total  = req_ch.first ? '0 : total_ff;
   assign acc_count  = req_ch.first ? '0 : count_ff;
   assign acc_full   = (acc_fill == FW'(WINDOW_DEPTH));

   assign need_drop  = (fill_ff != '0) && (total_ff > {1'b0, sum_limit});
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign out_load   = (state_ff == S_TRIM) && !need_drop && out_free;

   // saturating add of the window length
   assign count_sum  = {1'b0, count_ff} + (LW + 1)'(fill_ff);
   assign count_in   = count_sum[LW] ? {LW{1'b1}} : count_sum[LW-1:0];

   // a full buffer reads its oldest entry first; the new word lands there next cycle
   assign wr_en   = (accept && !acc_full) || (state_ff == S_POP_FULL);
   assign wr_addr = (state_ff == S_IDLE) ? acc_tail : tail_ff;
   assign wr_data = (state_ff == S_IDLE) ? req_ch.element : elem_ff;
   assign rd_en   = (accept && acc_full) || ((state_ff == S_TRIM) && need_drop);

   wslsc_ram #(
      .WIDTH (EW),
      .DEPTH (WINDOW_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (oldest_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && !out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  elem_ff   <= req_ch.element;
                  ovf_ff    <= 1'b0;
                  oldest_ff <= acc_oldest;
                  count_ff  <= acc_count;
                  if (acc_full) begin
                     state_ff <= S_POP_FULL;
                  end else begin
                     tail_ff  <= ptr_next(acc_tail);
                     fill_ff  <= acc_fill + 1'b1;
                     total_ff <= acc_total + TW'(req_ch.element);
                     state_ff <= S_TRIM;
                  end
               end
            end
            S_POP_FULL: begin
               total_ff  <= total_ff - TW'(rd_data) + TW'(elem_ff);
               oldest_ff <= ptr_next(oldest_ff);
               tail_ff   <= ptr_next(tail_ff);
               ovf_ff    <= 1'b1;
               state_ff  <= S_TRIM;
            end
            S_TRIM: begin
               if (need_drop) begin
                  state_ff <= S_DROP;
               end else if (out_free) begin
                  count_ff     <= count_in;
                  out_count_ff <= count_in;
                  out_len_ff   <= wslsc_pkg::LEN_W'(fill_ff);
                  out_ovf_ff   <= ovf_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_DROP: begin
               total_ff  <= total_ff - TW'(rd_data);
               oldest_ff <= ptr_next(oldest_ff);
               fill_ff   <= fill_ff - 1'b1;
               state_ff  <= S_TRIM;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.run_count     = out_count_ff;
   assign rsp_ch.window_length = out_len_ff;
   assign rsp_ch.overflow      = out_ovf_ff;

   // tail must sit fill entries past oldest, modulo the ring
   assign ring_sum = (FW + 1)'(oldest_ff) + (FW + 1)'(fill_ff);
   assign ring_end = (ring_sum >= (FW + 1)'(WINDOW_DEPTH)) ?
                     ring_sum - (FW + 1)'(WINDOW_DEPTH) : ring_sum;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(WINDOW_DEPTH))
      else $error("window fill beyond buffer depth");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      (FW + 1)'(tail_ff) == ring_end)
      else $error("tail pointer out of step with oldest and fill");

   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 |-> total_ff == '0)
      else $error("empty window with nonzero sum");

   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("store read and written in one cycle");

   a_result_in_limit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> total_ff <= {1'b0, sum_limit})
      else $error("result issued with window sum above limit");

endmodule

### sv/window_sum_limited_subarray_count.sv
`timescale 1ns / 1ps
// Top level of the window-sum limited run counter: limit register and sequencer.
// Depends on wslsc_pkg, wslsc_req_if, wslsc_rsp_if and wslsc_ctrl.
//
//  port     | dir | contents
//  ---------+-----+------------------------------------------------
//  req_ch   | in  | element[31:0], first          valid/ready
//  rsp_ch   | out | run_count[47:0], window_length[10:0], overflow
//  csr_*    | in  | csr_wr_en, csr_wr_data[47:0]  (sum_limit)
//
// An element is accepted, the oldest entry is replaced if the buffer was full,
// and one drop is made per element leaving the window: each drop is a read
// of the store followed by the subtract. Reset is synchronous, clears all window
// state and the limit, and needs no clearing pass. A new element is taken while
// the last result waits; a stalled result holds the sequencer before its output.
module window_sum_limited_subarray_count #(
   parameter int WINDOW_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   wslsc_req_if.sink                     req_ch,
   wslsc_rsp_if.source                   rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [wslsc_pkg::LIMIT_W-1:0] csr_wr_data
);

   logic [wslsc_pkg::LIMIT_W-1:0] sum_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_limit_ff <= '0;
      end else if (csr_wr_en) begin
         sum_limit_ff <= csr_wr_data;
      end
   end

   wslsc_ctrl #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sum_limit (sum_limit_ff),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

endmodule
